// ===== rtl/core/ncr_pkg.sv =====
package ncr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int MAX_STEPS     = 255;

    localparam int ACC_W  = 68;
    localparam int OPD_W  = 33;
    localparam int PROD_W = 2 * OPD_W;
    localparam int ADDR_W = 5;
    localparam int PC_W   = 8;
    localparam int DEN_W  = 64;
    localparam int QUO_W  = 32;

    // configuration register indexes
    localparam logic [2:0] REG_ROOT0_RE  = 3'd0;
    localparam logic [2:0] REG_ROOT0_IM  = 3'd1;
    localparam logic [2:0] REG_ROOT1_RE  = 3'd2;
    localparam logic [2:0] REG_ROOT1_IM  = 3'd3;
    localparam logic [2:0] REG_ROOT2_RE  = 3'd4;
    localparam logic [2:0] REG_ROOT2_IM  = 3'd5;
    localparam logic [2:0] REG_STEP_CNT  = 3'd6;

    // micro-op codes
    localparam logic [3:0] OP_LD   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SAT  = 4'd2;
    localparam logic [3:0] OP_WR   = 4'd3;
    localparam logic [3:0] OP_WRX  = 4'd4;
    localparam logic [3:0] OP_MULF = 4'd5;
    localparam logic [3:0] OP_MULX = 4'd6;
    localparam logic [3:0] OP_DEN  = 4'd7;
    localparam logic [3:0] OP_DIV  = 4'd8;
    localparam logic [3:0] OP_CMP  = 4'd9;
    localparam logic [3:0] OP_TEST = 4'd10;
    localparam logic [3:0] OP_LOOP = 4'd11;
    localparam logic [3:0] OP_DONE = 4'd12;

    // operand space: 0..7 fixed sources, 8..31 scratch ram
    localparam logic [ADDR_W-1:0] A_R0R = 5'd0;
    localparam logic [ADDR_W-1:0] A_R0I = 5'd1;
    localparam logic [ADDR_W-1:0] A_R1R = 5'd2;
    localparam logic [ADDR_W-1:0] A_R1I = 5'd3;
    localparam logic [ADDR_W-1:0] A_R2R = 5'd4;
    localparam logic [ADDR_W-1:0] A_R2I = 5'd5;
    localparam logic [ADDR_W-1:0] A_SR  = 5'd6;
    localparam logic [ADDR_W-1:0] A_SI  = 5'd7;
    localparam logic [ADDR_W-1:0] A_ZR  = 5'd8;
    localparam logic [ADDR_W-1:0] A_ZI  = 5'd9;
    localparam logic [ADDR_W-1:0] A_BR  = 5'd10;
    localparam logic [ADDR_W-1:0] A_BI  = 5'd11;
    localparam logic [ADDR_W-1:0] A_CR  = 5'd12;
    localparam logic [ADDR_W-1:0] A_CI  = 5'd13;
    localparam logic [ADDR_W-1:0] A_DR  = 5'd14;
    localparam logic [ADDR_W-1:0] A_DI  = 5'd15;
    localparam logic [ADDR_W-1:0] A_AR  = 5'd16;
    localparam logic [ADDR_W-1:0] A_AI  = 5'd17;
    localparam logic [ADDR_W-1:0] A_ER  = 5'd18;
    localparam logic [ADDR_W-1:0] A_EI  = 5'd19;
    localparam logic [ADDR_W-1:0] A_FR  = 5'd20;
    localparam logic [ADDR_W-1:0] A_FI  = 5'd21;
    localparam logic [ADDR_W-1:0] A_Z2R = 5'd22;
    localparam logic [ADDR_W-1:0] A_Z2I = 5'd23;
    localparam logic [ADDR_W-1:0] A_Z3R = 5'd24;
    localparam logic [ADDR_W-1:0] A_Z3I = 5'd25;
    localparam logic [ADDR_W-1:0] A_BZR = 5'd26;
    localparam logic [ADDR_W-1:0] A_BZI = 5'd27;
    localparam logic [ADDR_W-1:0] A_GR  = 5'd28;
    localparam logic [ADDR_W-1:0] A_GI  = 5'd29;
    localparam logic [ADDR_W-1:0] A_HR  = 5'd30;
    localparam logic [ADDR_W-1:0] A_HI  = 5'd31;
    // reused inside the loop
    localparam logic [ADDR_W-1:0] A_PR  = 5'd16;
    localparam logic [ADDR_W-1:0] A_PI  = 5'd17;
    localparam logic [ADDR_W-1:0] A_DPR = 5'd18;
    localparam logic [ADDR_W-1:0] A_DPI = 5'd19;
    localparam logic [ADDR_W-1:0] A_QR  = 5'd20;
    localparam logic [ADDR_W-1:0] A_QI  = 5'd21;
    localparam logic [ADDR_W-1:0] A_TR  = 5'd22;
    localparam logic [ADDR_W-1:0] A_TI  = 5'd23;

    localparam logic [PC_W-1:0] PC_TOP  = 8'd58;
    localparam logic [PC_W-1:0] PC_FIN  = 8'd141;
    localparam logic [PC_W-1:0] PC_DONE = 8'd168;

    typedef struct packed {
        logic [3:0]        op;
        logic              neg;
        logic              clr;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [1:0]        k;
    } uop_t;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DEN_W-1:0]  mag;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    function automatic uop_t mk(input logic [3:0] op, input logic neg, input logic clr,
                                input logic [ADDR_W-1:0] dst, input logic [ADDR_W-1:0] a,
                                input logic [ADDR_W-1:0] b);
        uop_t u;
        u.op  = op;
        u.neg = neg;
        u.clr = clr;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        u.k   = 2'd0;
        return u;
    endfunction

    // complex multiply, six steps
    function automatic uop_t cmul_step(input logic [2:0] off, input logic [ADDR_W-1:0] d,
                                       input logic [ADDR_W-1:0] a,
                                       input logic [ADDR_W-1:0] b);
        uop_t u;
        case (off)
            3'd0:    u = mk(OP_MULF, 1'b0, 1'b1, d, a, b);
            3'd1:    u = mk(OP_MULF, 1'b1, 1'b0, d, a + 5'd1, b + 5'd1);
            3'd2:    u = mk(OP_WR, 1'b0, 1'b0, d, a, b);
            3'd3:    u = mk(OP_MULF, 1'b0, 1'b1, d, a, b + 5'd1);
            3'd4:    u = mk(OP_MULF, 1'b0, 1'b0, d, a + 5'd1, b);
            default: u = mk(OP_WR, 1'b0, 1'b0, d + 5'd1, a, b);
        endcase
        return u;
    endfunction

    // squared distance to root k and compare, nine steps
    function automatic uop_t dist_step(input logic [3:0] off, input logic [1:0] k);
        uop_t u;
        logic [ADDR_W-1:0] rr;
        logic [ADDR_W-1:0] ri;
        rr = {2'b00, k, 1'b0};
        ri = {2'b00, k, 1'b1};
        case (off)
            4'd0:    u = mk(OP_LD, 1'b0, 1'b0, A_TR, rr, rr);
            4'd1:    u = mk(OP_ADD, 1'b1, 1'b0, A_TR, A_ZR, A_ZR);
            4'd2:    u = mk(OP_WRX, 1'b0, 1'b0, A_TR, A_TR, A_TR);
            4'd3:    u = mk(OP_LD, 1'b0, 1'b0, A_TI, ri, ri);
            4'd4:    u = mk(OP_ADD, 1'b1, 1'b0, A_TI, A_ZI, A_ZI);
            4'd5:    u = mk(OP_WRX, 1'b0, 1'b0, A_TI, A_TI, A_TI);
            4'd6:    u = mk(OP_MULX, 1'b0, 1'b1, A_TR, A_TR, A_TR);
            4'd7:    u = mk(OP_MULX, 1'b0, 1'b0, A_TI, A_TI, A_TI);
            default: begin
                u   = mk(OP_CMP, 1'b0, 1'b0, A_TR, A_TR, A_TR);
                u.k = k;
            end
        endcase
        return u;
    endfunction

    // three-term saturating sum: ld x, add y, sat, add z, wr d
    function automatic uop_t sum3_step(input logic [2:0] off, input logic [ADDR_W-1:0] d,
                                       input logic [ADDR_W-1:0] x,
                                       input logic [ADDR_W-1:0] y,
                                       input logic [ADDR_W-1:0] z);
        uop_t u;
        case (off)
            3'd0:    u = mk(OP_LD, 1'b0, 1'b0, d, x, x);
            3'd1:    u = mk(OP_ADD, 1'b0, 1'b0, d, y, y);
            3'd2:    u = mk(OP_SAT, 1'b0, 1'b0, d, y, y);
            3'd3:    u = mk(OP_ADD, 1'b0, 1'b0, d, z, z);
            default: u = mk(OP_WR, 1'b0, 1'b0, d, z, z);
        endcase
        return u;
    endfunction

    function automatic uop_t ncr_prog(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc) inside
            8'd0:          u = mk(OP_LD, 1'b0, 1'b0, A_BR, A_R0R, A_R0R);
            8'd1:          u = mk(OP_ADD, 1'b0, 1'b0, A_BR, A_R1R, A_R1R);
            8'd2:          u = mk(OP_SAT, 1'b0, 1'b0, A_BR, A_R1R, A_R1R);
            8'd3:          u = mk(OP_ADD, 1'b0, 1'b0, A_BR, A_R2R, A_R2R);
            8'd4:          u = mk(OP_SAT, 1'b0, 1'b0, A_BR, A_R2R, A_R2R);
            8'd5:          u = mk(OP_WR, 1'b0, 1'b0, A_BR, A_BR, A_BR);
            8'd6:          u = mk(OP_LD, 1'b1, 1'b0, A_BR, A_BR, A_BR);
            8'd7:          u = mk(OP_WR, 1'b0, 1'b0, A_BR, A_BR, A_BR);
            8'd8:          u = mk(OP_LD, 1'b0, 1'b0, A_BI, A_R0I, A_R0I);
            8'd9:          u = mk(OP_ADD, 1'b0, 1'b0, A_BI, A_R1I, A_R1I);
            8'd10:         u = mk(OP_SAT, 1'b0, 1'b0, A_BI, A_R1I, A_R1I);
            8'd11:         u = mk(OP_ADD, 1'b0, 1'b0, A_BI, A_R2I, A_R2I);
            8'd12:         u = mk(OP_SAT, 1'b0, 1'b0, A_BI, A_R2I, A_R2I);
            8'd13:         u = mk(OP_WR, 1'b0, 1'b0, A_BI, A_BI, A_BI);
            8'd14:         u = mk(OP_LD, 1'b1, 1'b0, A_BI, A_BI, A_BI);
            8'd15:         u = mk(OP_WR, 1'b0, 1'b0, A_BI, A_BI, A_BI);
            [8'd16:8'd21]: u = cmul_step(3'(pc - 8'd16), A_AR, A_R0R, A_R1R);
            [8'd22:8'd27]: u = cmul_step(3'(pc - 8'd22), A_ER, A_R1R, A_R2R);
            [8'd28:8'd33]: u = cmul_step(3'(pc - 8'd28), A_FR, A_R0R, A_R2R);
            [8'd34:8'd38]: u = sum3_step(3'(pc - 8'd34), A_CR, A_AR, A_ER, A_FR);
            [8'd39:8'd43]: u = sum3_step(3'(pc - 8'd39), A_CI, A_AI, A_EI, A_FI);
            [8'd44:8'd49]: u = cmul_step(3'(pc - 8'd44), A_DR, A_AR, A_R2R);
            8'd50:         u = mk(OP_LD, 1'b1, 1'b0, A_DR, A_DR, A_DR);
            8'd51:         u = mk(OP_WR, 1'b0, 1'b0, A_DR, A_DR, A_DR);
            8'd52:         u = mk(OP_LD, 1'b1, 1'b0, A_DI, A_DI, A_DI);
            8'd53:         u = mk(OP_WR, 1'b0, 1'b0, A_DI, A_DI, A_DI);
            8'd54:         u = mk(OP_LD, 1'b0, 1'b0, A_ZR, A_SR, A_SR);
            8'd55:         u = mk(OP_WR, 1'b0, 1'b0, A_ZR, A_SR, A_SR);
            8'd56:         u = mk(OP_LD, 1'b0, 1'b0, A_ZI, A_SI, A_SI);
            8'd57:         u = mk(OP_WR, 1'b0, 1'b0, A_ZI, A_SI, A_SI);
            8'd58:         u = mk(OP_TEST, 1'b0, 1'b0, A_ZR, A_ZR, A_ZR);
            [8'd59:8'd64]: u = cmul_step(3'(pc - 8'd59), A_Z2R, A_ZR, A_ZR);
            [8'd65:8'd70]: u = cmul_step(3'(pc - 8'd65), A_Z3R, A_Z2R, A_ZR);
            [8'd71:8'd76]: u = cmul_step(3'(pc - 8'd71), A_BZR, A_BR, A_ZR);
            [8'd77:8'd82]: u = cmul_step(3'(pc - 8'd77), A_GR, A_BR, A_Z2R);
            [8'd83:8'd88]: u = cmul_step(3'(pc - 8'd83), A_HR, A_CR, A_ZR);
            8'd89:         u = mk(OP_LD, 1'b0, 1'b0, A_PR, A_Z3R, A_Z3R);
            8'd90:         u = mk(OP_ADD, 1'b0, 1'b0, A_PR, A_GR, A_GR);
            8'd91:         u = mk(OP_SAT, 1'b0, 1'b0, A_PR, A_GR, A_GR);
            [8'd92:8'd95]: u = sum3_step(3'(pc - 8'd91), A_PR, A_PR, A_HR, A_DR);
            8'd96:         u = mk(OP_LD, 1'b0, 1'b0, A_PI, A_Z3I, A_Z3I);
            8'd97:         u = mk(OP_ADD, 1'b0, 1'b0, A_PI, A_GI, A_GI);
            8'd98:         u = mk(OP_SAT, 1'b0, 1'b0, A_PI, A_GI, A_GI);
            [8'd99:8'd102]: u = sum3_step(3'(pc - 8'd98), A_PI, A_PI, A_HI, A_DI);
            8'd103:        u = mk(OP_LD, 1'b0, 1'b0, A_GR, A_BZR, A_BZR);
            8'd104:        u = mk(OP_ADD, 1'b0, 1'b0, A_GR, A_BZR, A_BZR);
            8'd105:        u = mk(OP_WR, 1'b0, 1'b0, A_GR, A_BZR, A_BZR);
            8'd106:        u = mk(OP_LD, 1'b0, 1'b0, A_GI, A_BZI, A_BZI);
            8'd107:        u = mk(OP_ADD, 1'b0, 1'b0, A_GI, A_BZI, A_BZI);
            8'd108:        u = mk(OP_WR, 1'b0, 1'b0, A_GI, A_BZI, A_BZI);
            8'd109:        u = mk(OP_LD, 1'b0, 1'b0, A_DPR, A_Z2R, A_Z2R);
            8'd110:        u = mk(OP_ADD, 1'b0, 1'b0, A_DPR, A_Z2R, A_Z2R);
            8'd111:        u = mk(OP_ADD, 1'b0, 1'b0, A_DPR, A_Z2R, A_Z2R);
            8'd112:        u = mk(OP_SAT, 1'b0, 1'b0, A_DPR, A_Z2R, A_Z2R);
            [8'd113:8'd116]: u = sum3_step(3'(pc - 8'd112), A_DPR, A_Z2R, A_GR, A_CR);
            8'd117:        u = mk(OP_LD, 1'b0, 1'b0, A_DPI, A_Z2I, A_Z2I);
            8'd118:        u = mk(OP_ADD, 1'b0, 1'b0, A_DPI, A_Z2I, A_Z2I);
            8'd119:        u = mk(OP_ADD, 1'b0, 1'b0, A_DPI, A_Z2I, A_Z2I);
            8'd120:        u = mk(OP_SAT, 1'b0, 1'b0, A_DPI, A_Z2I, A_Z2I);
            [8'd121:8'd124]: u = sum3_step(3'(pc - 8'd120), A_DPI, A_Z2I, A_GI, A_CI);
            8'd125:        u = mk(OP_MULX, 1'b0, 1'b1, A_DPR, A_DPR, A_DPR);
            8'd126:        u = mk(OP_MULX, 1'b0, 1'b0, A_DPR, A_DPI, A_DPI);
            8'd127:        u = mk(OP_DEN, 1'b0, 1'b0, A_DPR, A_DPR, A_DPR);
            8'd128:        u = mk(OP_MULX, 1'b0, 1'b1, A_QR, A_PR, A_DPR);
            8'd129:        u = mk(OP_MULX, 1'b0, 1'b0, A_QR, A_PI, A_DPI);
            8'd130:        u = mk(OP_DIV, 1'b0, 1'b0, A_QR, A_PI, A_DPI);
            8'd131:        u = mk(OP_MULX, 1'b0, 1'b1, A_QI, A_PI, A_DPR);
            8'd132:        u = mk(OP_MULX, 1'b1, 1'b0, A_QI, A_PR, A_DPI);
            8'd133:        u = mk(OP_DIV, 1'b0, 1'b0, A_QI, A_PR, A_DPI);
            8'd134:        u = mk(OP_LD, 1'b0, 1'b0, A_ZR, A_ZR, A_ZR);
            8'd135:        u = mk(OP_ADD, 1'b1, 1'b0, A_ZR, A_QR, A_QR);
            8'd136:        u = mk(OP_WR, 1'b0, 1'b0, A_ZR, A_QR, A_QR);
            8'd137:        u = mk(OP_LD, 1'b0, 1'b0, A_ZI, A_ZI, A_ZI);
            8'd138:        u = mk(OP_ADD, 1'b1, 1'b0, A_ZI, A_QI, A_QI);
            8'd139:        u = mk(OP_WR, 1'b0, 1'b0, A_ZI, A_QI, A_QI);
            8'd140:        u = mk(OP_LOOP, 1'b0, 1'b0, A_ZR, A_ZR, A_ZR);
            [8'd141:8'd149]: u = dist_step(4'(pc - 8'd141), 2'd0);
            [8'd150:8'd158]: u = dist_step(4'(pc - 8'd150), 2'd1);
            [8'd159:8'd167]: u = dist_step(4'(pc - 8'd159), 2'd2);
            default:       u = mk(OP_DONE, 1'b0, 1'b0, A_ZR, A_ZR, A_ZI);
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] ncr_sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if ((&x[ACC_W-1:31]) || (~|x[ACC_W-1:31])) begin
            r = x[31:0];
        end else if (x[ACC_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/newton_cubic_root_basin_unit.sv =====
// Newton iteration on the monic cubic whose three roots are set through the
// register port, in signed Q16.16. One starting point goes in, one item comes
// out: the last iterate, the index of the nearest root (lower index on a tie)
// and a flag when the derivative vanished. All arithmetic runs on one 33x33
// multiplier with an accumulator and one radix-2 divider, stepped by a small
// micro-op sequencer; each micro-op passes through operand read from the
// scratch ram, multiply and accumulate, and each divide holds the sequencer
// until the divider is done. The input is not ready while an item is in work.
module newton_cubic_root_basin_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_start_re,
    input  logic signed [31:0] s_start_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_nearest_root,
    output logic signed [31:0] m_final_re,
    output logic signed [31:0] m_final_im,
    output logic               m_degenerate
);

    localparam int FB  = ncr_pkg::FRACTION_BITS;
    localparam int AW  = ncr_pkg::ACC_W;
    localparam int OW  = ncr_pkg::OPD_W;
    localparam int PW  = ncr_pkg::PROD_W;
    localparam int DW  = ncr_pkg::DEN_W;

    localparam logic [1:0] PH_RD   = 2'd0;
    localparam logic [1:0] PH_OP   = 2'd1;
    localparam logic [1:0] PH_EX   = 2'd2;
    localparam logic [1:0] PH_WAIT = 2'd3;

    logic signed [31:0] root0_re_reg, root0_im_reg, root1_re_reg, root1_im_reg;
    logic signed [31:0] root2_re_reg, root2_im_reg;
    logic [7:0]         step_count_reg;

    logic               busy_reg;
    logic [1:0]         ph_reg;
    logic [ncr_pkg::PC_W-1:0] pc_reg;
    logic [7:0]         cnt_reg;
    logic               degen_reg;
    logic [1:0]         idx_reg;
    logic [DW-1:0]      best_reg;
    logic [DW-1:0]      den_reg;
    logic signed [31:0] sr_reg, si_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [OW-1:0] a_reg, b_reg;
    logic signed [PW-1:0] prod_reg;

    logic               m_valid_reg;
    logic [1:0]         nearest_reg;
    logic signed [31:0] final_re_reg, final_im_reg;
    logic               degenerate_reg;

    ncr_pkg::uop_t      uop;
    ncr_pkg::div_req_t  div_req;
    logic               div_done;
    logic signed [ncr_pkg::QUO_W-1:0] div_quo;

    logic signed [OW-1:0] fixed_src [8];
    logic [OW-1:0]      rd0, rd1;
    logic signed [OW-1:0] opa, opb;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] term, sterm, base, sum, acc_mag;
    logic signed [31:0] acc_sat;
    logic [DW-1:0]      dd;
    logic               ex;
    logic               cfg_wr;
    logic               out_load;
    logic               ram_we;
    logic [OW-1:0]      ram_wdata;
    logic               accept;

    assign uop    = ncr_pkg::ncr_prog(pc_reg);
    assign ex     = busy_reg && (ph_reg == PH_EX);
    assign cfg_wr = psel && penable && pwrite;
    assign accept = s_valid && !busy_reg;

    assign fixed_src[0] = OW'(root0_re_reg);
    assign fixed_src[1] = OW'(root0_im_reg);
    assign fixed_src[2] = OW'(root1_re_reg);
    assign fixed_src[3] = OW'(root1_im_reg);
    assign fixed_src[4] = OW'(root2_re_reg);
    assign fixed_src[5] = OW'(root2_im_reg);
    assign fixed_src[6] = OW'(sr_reg);
    assign fixed_src[7] = OW'(si_reg);

    assign opa  = (uop.a < 5'd8) ? fixed_src[uop.a[2:0]] : $signed(rd0);
    assign opb  = (uop.b < 5'd8) ? fixed_src[uop.b[2:0]] : $signed(rd1);
    assign prod = opa * opb;

    always_comb begin
        case (uop.op)
            ncr_pkg::OP_MULF: term = AW'(prod_reg >>> FB);
            ncr_pkg::OP_MULX: term = AW'(prod_reg);
            default:          term = AW'(a_reg);
        endcase
    end

    assign sterm = uop.neg ? -term : term;
    assign base  = ((uop.op == ncr_pkg::OP_LD) ||
                    (((uop.op == ncr_pkg::OP_MULF) || (uop.op == ncr_pkg::OP_MULX)) && uop.clr))
                   ? '0 : acc_reg;
    assign sum     = base + sterm;
    assign acc_sat = ncr_pkg::ncr_sat32(acc_reg);
    assign acc_mag = acc_reg[AW-1] ? -acc_reg : acc_reg;
    assign dd      = (|acc_reg[AW-1:DW]) ? {DW{1'b1}} : acc_reg[DW-1:0];

    assign out_load = ex && (uop.op == ncr_pkg::OP_DONE) && (!m_valid_reg || m_ready);

    assign div_req.start = ex && (uop.op == ncr_pkg::OP_DIV);
    assign div_req.neg   = acc_reg[AW-1];
    assign div_req.mag   = acc_mag[DW-1:0];
    assign div_req.den   = den_reg;

    assign ram_we = (ex && ((uop.op == ncr_pkg::OP_WR) || (uop.op == ncr_pkg::OP_WRX))) ||
                    (busy_reg && (ph_reg == PH_WAIT) && div_done);

    always_comb begin
        if (ph_reg == PH_WAIT) begin
            ram_wdata = OW'(div_quo);
        end else if (uop.op == ncr_pkg::OP_WRX) begin
            ram_wdata = acc_reg[OW-1:0];
        end else begin
            ram_wdata = OW'(acc_sat);
        end
    end

    ncr_ram #(
        .WIDTH (OW),
        .DEPTH (2 ** ncr_pkg::ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (uop.dst),
        .wdata  (ram_wdata),
        .raddr0 (uop.a),
        .raddr1 (uop.b),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    ncr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    // register port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root0_re_reg   <= 32'sd65536;
            root0_im_reg   <= 32'sd65536;
            root1_re_reg   <= 32'sd131072;
            root1_im_reg   <= 32'sd65536;
            root2_re_reg   <= 32'sd98304;
            root2_im_reg   <= 32'sd122294;
            step_count_reg <= 8'd10;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                ncr_pkg::REG_ROOT0_RE: root0_re_reg   <= pwdata;
                ncr_pkg::REG_ROOT0_IM: root0_im_reg   <= pwdata;
                ncr_pkg::REG_ROOT1_RE: root1_re_reg   <= pwdata;
                ncr_pkg::REG_ROOT1_IM: root1_im_reg   <= pwdata;
                ncr_pkg::REG_ROOT2_RE: root2_re_reg   <= pwdata;
                ncr_pkg::REG_ROOT2_IM: root2_im_reg   <= pwdata;
                ncr_pkg::REG_STEP_CNT: step_count_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            ncr_pkg::REG_ROOT0_RE: prdata = root0_re_reg;
            ncr_pkg::REG_ROOT0_IM: prdata = root0_im_reg;
            ncr_pkg::REG_ROOT1_RE: prdata = root1_re_reg;
            ncr_pkg::REG_ROOT1_IM: prdata = root1_im_reg;
            ncr_pkg::REG_ROOT2_RE: prdata = root2_re_reg;
            ncr_pkg::REG_ROOT2_IM: prdata = root2_im_reg;
            ncr_pkg::REG_STEP_CNT: prdata = {24'd0, step_count_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            ph_reg      <= PH_RD;
            pc_reg      <= '0;
            cnt_reg     <= 8'd0;
            degen_reg   <= 1'b0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (!busy_reg) begin
                if (accept) begin
                    busy_reg  <= 1'b1;
                    ph_reg    <= PH_RD;
                    pc_reg    <= '0;
                    degen_reg <= 1'b0;
                    idx_reg   <= 2'd0;
                    cnt_reg   <= (step_count_reg > 8'(ncr_pkg::MAX_STEPS))
                                 ? 8'(ncr_pkg::MAX_STEPS) : step_count_reg;
                end
            end else begin
                unique case (ph_reg)
                    PH_RD: ph_reg <= PH_OP;
                    PH_OP: ph_reg <= PH_EX;
                    PH_EX: begin
                        ph_reg <= PH_RD;
                        pc_reg <= pc_reg + 1'b1;
                        case (uop.op)
                            ncr_pkg::OP_DEN: begin
                                if (acc_reg == '0) begin
                                    degen_reg <= 1'b1;
                                    pc_reg    <= ncr_pkg::PC_DONE;
                                end
                            end
                            ncr_pkg::OP_DIV: begin
                                ph_reg <= PH_WAIT;
                                pc_reg <= pc_reg;
                            end
                            ncr_pkg::OP_CMP: begin
                                if ((uop.k == 2'd0) || (dd < best_reg)) begin
                                    idx_reg <= uop.k;
                                end
                            end
                            ncr_pkg::OP_TEST: begin
                                if (cnt_reg == 8'd0) begin
                                    pc_reg <= ncr_pkg::PC_FIN;
                                end
                            end
                            ncr_pkg::OP_LOOP: begin
                                cnt_reg <= cnt_reg - 8'd1;
                                pc_reg  <= ncr_pkg::PC_TOP;
                            end
                            ncr_pkg::OP_DONE: begin
                                pc_reg <= pc_reg;
                                ph_reg <= PH_EX;
                                if (out_load) begin
                                    busy_reg <= 1'b0;
                                    ph_reg   <= PH_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                    PH_WAIT: begin
                        if (div_done) begin
                            ph_reg <= PH_RD;
                            pc_reg <= pc_reg + 1'b1;
                        end
                    end
                    default: ph_reg <= PH_RD;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            sr_reg <= s_start_re;
            si_reg <= s_start_im;
        end
        if (busy_reg && (ph_reg == PH_OP)) begin
            a_reg    <= opa;
            b_reg    <= opb;
            prod_reg <= prod;
        end
        if (ex) begin
            case (uop.op)
                ncr_pkg::OP_LD, ncr_pkg::OP_ADD,
                ncr_pkg::OP_MULF, ncr_pkg::OP_MULX: acc_reg <= sum;
                ncr_pkg::OP_SAT: acc_reg <= AW'(acc_sat);
                ncr_pkg::OP_DEN: den_reg <= acc_reg[DW-1:0];
                ncr_pkg::OP_CMP: begin
                    if ((uop.k == 2'd0) || (dd < best_reg)) begin
                        best_reg <= dd;
                    end
                end
                default: ;
            endcase
        end
        if (out_load) begin
            nearest_reg    <= idx_reg;
            final_re_reg   <= a_reg[31:0];
            final_im_reg   <= b_reg[31:0];
            degenerate_reg <= degen_reg;
        end
    end

    assign s_ready        = !busy_reg;
    assign m_valid        = m_valid_reg;
    assign m_nearest_root = nearest_reg;
    assign m_final_re     = final_re_reg;
    assign m_final_im     = final_im_reg;
    assign m_degenerate   = degenerate_reg;

    a_degen_root0: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && degen_reg |-> idx_reg == 2'd0)
        else $error("degenerate item with nonzero root index");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_nearest_root != 2'd3)
        else $error("root index out of range");

    a_wait_div: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (ph_reg == PH_WAIT) |-> uop.op == ncr_pkg::OP_DIV)
        else $error("divider wait outside a divide op");

    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> busy_reg && (ph_reg == PH_WAIT))
        else $error("divider finished with no divide pending");

endmodule

// ===== rtl/core/ncr_ram.sv =====
module ncr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/core/ncr_div.sv =====
module ncr_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ncr_pkg::div_req_t                 req,
    output logic                              done,
    output logic signed [ncr_pkg::QUO_W-1:0]  quo
);

    localparam int FB  = ncr_pkg::FRACTION_BITS;
    localparam int DW  = ncr_pkg::DEN_W;
    localparam int QW  = ncr_pkg::QUO_W;

    logic              busy_reg;
    logic [4:0]        cnt_reg;
    logic              ovf_reg;
    logic              neg_reg;
    logic [DW-1:0]     den_reg;
    logic [DW-1:0]     rem_reg;
    logic [QW-1:0]     low_reg;
    logic [QW-1:0]     q_reg;
    logic              done_reg;
    logic [QW-1:0]     quo_reg;

    logic [DW+QW-1:0]  n_full;
    logic              ovf;
    logic [DW:0]       r2;
    logic              take;
    logic [QW-1:0]     q_next;
    logic [QW-1:0]     q_fin;
    logic [QW-1:0]     lim;
    logic [QW-1:0]     q_clamp;
    logic              finish;

    assign n_full = (DW+QW)'(req.mag) << FB;
    assign ovf    = n_full >= {req.den, {QW{1'b0}}};

    assign r2      = {rem_reg, low_reg[QW-1]};
    assign take    = r2 >= {1'b0, den_reg};
    assign q_next  = {q_reg[QW-2:0], take};
    assign q_fin   = ovf_reg ? {QW{1'b1}} : q_next;
    assign lim     = neg_reg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign q_clamp = (q_fin > lim) ? lim : q_fin;
    assign finish  = busy_reg && (ovf_reg || (cnt_reg == 5'd31));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= finish;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= 5'd0;
            ovf_reg <= ovf;
            neg_reg <= req.neg;
            den_reg <= req.den;
            rem_reg <= DW'(n_full >> QW);
            low_reg <= n_full[QW-1:0];
            q_reg   <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            rem_reg <= take ? DW'(r2 - {1'b0, den_reg}) : DW'(r2);
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= q_next;
        end
        if (finish) begin
            quo_reg <= neg_reg ? (~q_clamp + 1'b1) : q_clamp;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        longint re;
        longint im;
    } cpx_t;

    typedef struct {
        logic [1:0]        root;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic              degen;
    } basin_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_start_re;
    logic signed [31:0] s_start_im;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_nearest_root;
    logic signed [31:0] m_final_re;
    logic signed [31:0] m_final_im;
    logic               m_degenerate;

    longint root_re_cfg [3];
    longint root_im_cfg [3];
    int     steps_cfg;
    basin_t basin_q [$];
    int     errors;
    int     send_idle_pct;
    int     recv_stall_pct;

    newton_cubic_root_basin_unit dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(200_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> ncr_pkg::FRACTION_BITS;
    endfunction

    function automatic cpx_t c_add(input cpx_t a, input cpx_t b);
        cpx_t r;
        r.re = sat32(a.re + b.re);
        r.im = sat32(a.im + b.im);
        return r;
    endfunction

    function automatic cpx_t c_neg(input cpx_t a);
        cpx_t r;
        r.re = sat32(-a.re);
        r.im = sat32(-a.im);
        return r;
    endfunction

    function automatic cpx_t c_scale(input cpx_t a, input longint k);
        cpx_t r;
        r.re = sat32(a.re * k);
        r.im = sat32(a.im * k);
        return r;
    endfunction

    function automatic cpx_t c_mul(input cpx_t a, input cpx_t b);
        cpx_t r;
        r.re = sat32(fmul(a.re, b.re) - fmul(a.im, b.im));
        r.im = sat32(fmul(a.re, b.im) + fmul(a.im, b.re));
        return r;
    endfunction

    function automatic longint quotient(input longint unsigned mag, input bit neg,
                                        input longint unsigned den);
        longint unsigned lim;
        longint unsigned q;
        longint unsigned r;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q = mag / den;
        r = mag % den;
        if (q > (lim >> ncr_pkg::FRACTION_BITS)) begin
            q = lim;
        end else begin
            for (int i = 0; i < ncr_pkg::FRACTION_BITS; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
            if (q > lim) q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint newton_div(input longint x1, input longint x2,
                                          input longint den);
        logic signed [65:0] a;
        logic signed [65:0] b;
        logic signed [65:0] s;
        logic signed [65:0] m;
        a = 66'(x1);
        b = 66'(x2);
        s = a + b;
        m = (s < 0) ? -s : s;
        return quotient(m[63:0], s < 0, den);
    endfunction

    function automatic longint unsigned dist2(input longint rre, input longint rim,
                                              input cpx_t z);
        longint dr;
        longint di;
        longint unsigned mr;
        longint unsigned mi;
        logic [64:0] s;
        dr = rre - z.re;
        di = rim - z.im;
        mr = dr < 0 ? -dr : dr;
        mi = di < 0 ? -di : di;
        s = {1'b0, mr * mr} + {1'b0, mi * mi};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic basin_t predict_basin(input logic signed [31:0] sre,
                                             input logic signed [31:0] sim);
        cpx_t r [3];
        cpx_t z, p01, p12, p02, b, c, d, z2, z3, bz, p, dp;
        longint den;
        longint unsigned best;
        longint unsigned dd;
        int n;
        basin_t res;
        for (int k = 0; k < 3; k++) begin
            r[k].re = root_re_cfg[k];
            r[k].im = root_im_cfg[k];
        end
        z.re = longint'(sre);
        z.im = longint'(sim);
        p01 = c_mul(r[0], r[1]);
        p12 = c_mul(r[1], r[2]);
        p02 = c_mul(r[0], r[2]);
        b = c_neg(c_add(c_add(r[0], r[1]), r[2]));
        c = c_add(c_add(p01, p12), p02);
        d = c_neg(c_mul(p01, r[2]));
        n = steps_cfg > ncr_pkg::MAX_STEPS ? ncr_pkg::MAX_STEPS : steps_cfg;
        res.degen = 1'b0;
        res.root = 2'd0;
        for (int l = 0; l < n; l++) begin
            z2 = c_mul(z, z);
            z3 = c_mul(z2, z);
            bz = c_mul(b, z);
            p = c_add(c_add(c_add(z3, c_mul(b, z2)), c_mul(c, z)), d);
            dp = c_add(c_add(c_scale(z2, 3), c_scale(bz, 2)), c);
            den = dp.re * dp.re + dp.im * dp.im;
            if (den == 0) begin
                res.degen = 1'b1;
                break;
            end
            begin
                cpx_t q;
                q.re = newton_div(p.re * dp.re, p.im * dp.im, den);
                q.im = newton_div(p.im * dp.re, -(p.re * dp.im), den);
                z.re = sat32(z.re - q.re);
                z.im = sat32(z.im - q.im);
            end
        end
        if (!res.degen) begin
            best = dist2(r[0].re, r[0].im, z);
            dd = dist2(r[1].re, r[1].im, z);
            if (dd < best) begin
                best = dd;
                res.root = 2'd1;
            end
            dd = dist2(r[2].re, r[2].im, z);
            if (dd < best) res.root = 2'd2;
        end
        res.re = z.re[31:0];
        res.im = z.im[31:0];
        return res;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ncr_pkg::REG_ROOT0_RE: root_re_cfg[0] = longint'(signed'(value));
            ncr_pkg::REG_ROOT0_IM: root_im_cfg[0] = longint'(signed'(value));
            ncr_pkg::REG_ROOT1_RE: root_re_cfg[1] = longint'(signed'(value));
            ncr_pkg::REG_ROOT1_IM: root_im_cfg[1] = longint'(signed'(value));
            ncr_pkg::REG_ROOT2_RE: root_re_cfg[2] = longint'(signed'(value));
            ncr_pkg::REG_ROOT2_IM: root_im_cfg[2] = longint'(signed'(value));
            ncr_pkg::REG_STEP_CNT: steps_cfg = int'(value[7:0]);
            default: ;
        endcase
    endtask

    task automatic set_roots(input logic [31:0] a_re, input logic [31:0] a_im,
                             input logic [31:0] b_re, input logic [31:0] b_im,
                             input logic [31:0] c_re, input logic [31:0] c_im,
                             input logic [7:0] steps);
        reg_write(ncr_pkg::REG_ROOT0_RE, a_re);
        reg_write(ncr_pkg::REG_ROOT0_IM, a_im);
        reg_write(ncr_pkg::REG_ROOT1_RE, b_re);
        reg_write(ncr_pkg::REG_ROOT1_IM, b_im);
        reg_write(ncr_pkg::REG_ROOT2_RE, c_re);
        reg_write(ncr_pkg::REG_ROOT2_IM, c_im);
        reg_write(ncr_pkg::REG_STEP_CNT, {24'd0, steps});
    endtask

    task automatic send_point(input logic [31:0] sre, input logic [31:0] sim);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_start_re <= sre;
        s_start_im <= sim;
        do @(posedge aclk); while (!s_ready);
        basin_q.push_back(predict_basin(sre, sim));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (basin_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        basin_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (basin_q.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    e = basin_q.pop_front();
                    if (m_nearest_root !== e.root) begin
                        $error("nearest_root exp %0d got %0d", e.root, m_nearest_root);
                        errors++;
                    end
                    if (m_final_re !== e.re) begin
                        $error("final_re exp %0d got %0d", e.re, m_final_re);
                        errors++;
                    end
                    if (m_final_im !== e.im) begin
                        $error("final_im exp %0d got %0d", e.im, m_final_im);
                        errors++;
                    end
                    if (m_degenerate !== e.degen) begin
                        $error("degenerate exp %0d got %0d", e.degen, m_degenerate);
                        errors++;
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_config();
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0001_8000, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        drain();
    endtask

    task automatic test_step_extremes();
        set_roots(32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 8'd0);
        send_point(32'h0000_4000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        reg_write(ncr_pkg::REG_STEP_CNT, 32'd255);
        send_point(32'h0000_3000, 32'hFFFF_2000);
        drain();
        reg_write(ncr_pkg::REG_STEP_CNT, 32'd1);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h0002_0000, 32'hFFFE_0000);
        drain();
    endtask

    task automatic test_zero_derivative();
        // triple root at origin: derivative vanishes at zero
        set_roots(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'd3);
        send_point(32'h0, 32'h0);
        send_point(32'h0001_0000, 32'h0);
        drain();
        // double root at one: derivative vanishes there
        set_roots(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'hFFFE_0000, 32'h0, 8'd4);
        send_point(32'h0001_0000, 32'h0);
        drain();
    endtask

    task automatic test_ties_and_overflow();
        // equal roots and equidistant points tie toward the lower index
        set_roots(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 8'd0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0001_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0005_0000);
        drain();
        // distances that saturate
        set_roots(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 8'd0);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        drain();
        // write to an unused register is dropped
        reg_write(REG_UNUSED, 32'h0000_0005);
        send_point(32'h0, 32'h0);
        drain();
    endtask

    task automatic test_random(input int items);
        logic [31:0] v [6];
        logic [31:0] sre;
        logic [31:0] sim;
        logic [7:0]  steps;
        int k;
        int sel;
        int sent;
        sent = 0;
        while (sent < items) begin
            for (int j = 0; j < 6; j++) begin
                if ($urandom_range(9) == 0) v[j] = $urandom();
                else v[j] = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            end
            sel = $urandom_range(99);
            if (sel < 1) steps = 8'd255;
            else if (sel < 8) steps = 8'd0;
            else if (sel < 12) steps = 8'($urandom_range(8, 20));
            else steps = 8'($urandom_range(1, 5));
            set_roots(v[0], v[1], v[2], v[3], v[4], v[5], steps);
            repeat (steps > 20 ? 2 : 25) begin
                k = $urandom_range(2);
                case ($urandom_range(3))
                    0: begin
                        sre = $urandom();
                        sim = $urandom();
                    end
                    1: begin
                        sre = 32'(root_re_cfg[k] + $urandom_range(32'h2_0000) - 32'h1_0000);
                        sim = 32'(root_im_cfg[k] + $urandom_range(32'h2_0000) - 32'h1_0000);
                    end
                    default: begin
                        sre = $urandom_range(32'h0006_0000) - 32'h0003_0000;
                        sim = $urandom_range(32'h0006_0000) - 32'h0003_0000;
                    end
                endcase
                send_point(sre, sim);
                sent++;
            end
            drain();
        end
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 26;
        recv_stall_pct = 58;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_start_re = '0;
        s_start_im = '0;
        root_re_cfg = '{64'sd65536, 64'sd131072, 64'sd98304};
        root_im_cfg = '{64'sd65536, 64'sd65536, 64'sd122294};
        steps_cfg = 10;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_step_extremes();
        test_zero_derivative();
        test_ties_and_overflow();
        test_random(250);
        send_idle_pct = 58;
        recv_stall_pct = 26;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(250);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
